// File: rtl/core/time_to_seven_segment_frames_assert.svh
// ----------------------------------------------------------------------------
// time_to_seven_segment_frames assertion macros
// shared property forms for the display driver checkers
// ----------------------------------------------------------------------------
`ifndef TIME_TO_SEVEN_SEGMENT_FRAMES_ASSERT_SVH
`define TIME_TO_SEVEN_SEGMENT_FRAMES_ASSERT_SVH

// same-cycle implication, held off during reset
`define TTSS_ASSERT_IMPLY(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) \
        (ante) |-> (cons)) else $error("ttss assertion failed");

// next-cycle implication, held off during reset
`define TTSS_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) \
        (ante) |=> (cons)) else $error("ttss assertion failed");

`endif

// File: rtl/core/ttss_pkg.sv
// ----------------------------------------------------------------------------
// ttss_pkg
// types, constants and helper functions of the seven-segment frame driver
// ----------------------------------------------------------------------------
`default_nettype none

package ttss_pkg;

    // payload widths
    localparam int DATA_W    = 32;
    localparam int SEG_W     = 8;
    localparam int SEL_W     = 4;
    localparam int POS_W     = 2;
    localparam int MASK_W    = 4;
    localparam int DIGIT_W   = 4;

    // frame count limit and default digit count
    localparam int MAX_FRAMES         = 4;
    localparam int NUM_DIGITS_DEFAULT = 4;

    // register reset and decimal point clear mask
    localparam logic [MASK_W-1:0] DOT_MASK_RESET = 4'd2;
    localparam logic [SEG_W-1:0]  DP_CLEAR       = 8'h7F;

    // binary to decimal conversion, bits consumed per cycle when not held by a full queue
    localparam int CONV_STEPS    = 4;
    localparam int BITS_PER_STEP = DATA_W / CONV_STEPS;
    localparam int CNT_W         = $clog2(CONV_STEPS);

    // queue between converter and frame emitter
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // decimal digits of one item, frame 0 is leftmost
    typedef logic [MAX_FRAMES-1:0][DIGIT_W-1:0] digit_row_t;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    // active-low common-anode segment pattern, decimal point dark
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hFF;
        endcase
        return code;
    endfunction

    // one-hot digit select, zero when the position falls outside the four select bits
    function automatic logic [SEL_W-1:0] select_code(input int shift);
        logic [SEL_W-1:0] code;
        for (int k = 0; k < SEL_W; k++) begin
            code[k] = (shift == k);
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ttss_front.sv
// ----------------------------------------------------------------------------
// ttss_front
// accepts time values and converts them to decimal digits, eight bits a cycle unless held by a full queue
// ----------------------------------------------------------------------------
`default_nettype none

module ttss_front
    import ttss_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] time_ms,
    input  wire q_stat_t           q_stat,
    output logic                   push,
    output digit_row_t             push_row
);

    // one decimal digit below the rightmost shown one is needed
    localparam int NDEC  = NUM_DIGITS + 1;
    localparam int BCD_W = NDEC * DIGIT_W;
    localparam int NF    = (NUM_DIGITS < MAX_FRAMES) ? NUM_DIGITS : MAX_FRAMES;

    logic [DATA_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    logic [DATA_W-1:0] bin_step;
    logic [BCD_W-1:0]  bcd_step;
    logic              last_step;
    logic              advance;
    logic              accept;

    // double dabble over one slice of input bits, upper digits drop off
    always_comb
    begin
        bin_step = bin_reg;
        bcd_step = bcd_reg;
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            for (int k = 0; k < NDEC; k++) begin
                if (bcd_step[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                    bcd_step[k*DIGIT_W +: DIGIT_W] = bcd_step[k*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            bcd_step = {bcd_step[BCD_W-2:0], bin_step[DATA_W-1]};
            bin_step = {bin_step[DATA_W-2:0], 1'b0};
        end
    end

    // digits of the shown positions, leftmost first
    always_comb
    begin
        push_row = '0;
        for (int f = 0; f < MAX_FRAMES; f++) begin
            if (f < NF) begin
                push_row[f] = bcd_step[((f < NF) ? (NUM_DIGITS - f) : 0)*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // handshake, converter hands over on its last slice
    assign last_step = busy_reg && (cnt_reg == CNT_W'(CONV_STEPS - 1));
    assign push      = last_step && !q_stat.full;
    assign advance   = busy_reg && !(last_step && q_stat.full);
    assign in_ready  = !busy_reg || push;
    assign accept    = in_valid && in_ready;

    // converter next state
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (accept) begin
            bin_next  = time_ms;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (advance) begin
            bin_next  = bin_step;
            bcd_next  = bcd_step;
            cnt_next  = cnt_reg + CNT_W'(1);
            busy_next = !push;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // working value
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/ttss_queue.sv
// ----------------------------------------------------------------------------
// ttss_queue
// short first-in first-out queue of digit rows between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module ttss_queue
    import ttss_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire digit_row_t push_row,
    input  wire logic       pop,
    output q_stat_t         q_stat,
    output digit_row_t      head_row
);

    digit_row_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    // pointer wrap
    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
        return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
    endfunction

    assign q_stat.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.not_empty = (count_reg != '0);
    assign head_row         = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_row;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ttss_back.sv
// ----------------------------------------------------------------------------
// ttss_back
// turns a queued digit row into display frames, one frame a cycle while out_ready does not stall it
// ----------------------------------------------------------------------------
`default_nettype none

module ttss_back
    import ttss_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire q_stat_t           q_stat,
    input  wire digit_row_t        head_row,
    input  wire logic [MASK_W-1:0] dot_mask,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [SEG_W-1:0]       segments,
    output logic [SEL_W-1:0]       digit_select,
    output logic [POS_W-1:0]       position,
    output logic                   last_frame
);

    localparam int NF = (NUM_DIGITS < MAX_FRAMES) ? NUM_DIGITS : MAX_FRAMES;

    logic [POS_W-1:0] frame_reg, frame_next;
    logic             out_valid_reg, out_valid_next;
    logic [SEG_W-1:0] segments_reg, segments_next;
    logic [SEL_W-1:0] select_reg, select_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic             last_reg, last_next;

    logic             load;
    logic             emit;
    logic             is_last;
    logic [SEG_W-1:0] seg_frame;

    // output stage takes a new frame when empty or drained
    assign load    = !out_valid_reg || out_ready;
    assign emit    = load && q_stat.not_empty;
    assign is_last = (frame_reg == POS_W'(NF - 1));
    assign pop     = emit && is_last;

    // segment byte with decimal point
    always_comb
    begin
        seg_frame = seg_code(head_row[frame_reg]);
        if (dot_mask[frame_reg]) begin
            seg_frame = seg_frame & DP_CLEAR;
        end
    end

    // frame sequencing and output register next values
    always_comb
    begin
        frame_next     = frame_reg;
        out_valid_next = out_valid_reg;
        segments_next  = segments_reg;
        select_next    = select_reg;
        position_next  = position_reg;
        last_next      = last_reg;
        if (emit) begin
            frame_next     = is_last ? '0 : frame_reg + POS_W'(1);
            out_valid_next = 1'b1;
            segments_next  = seg_frame;
            select_next    = select_code(NUM_DIGITS - 1 - int'(frame_reg));
            position_next  = frame_reg;
            last_next      = is_last;
        end else if (load) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // frame payload
    always_ff @(posedge clk)
    begin
        segments_reg <= segments_next;
        select_reg   <= select_next;
        position_reg <= position_next;
        last_reg     <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign segments     = segments_reg;
    assign digit_select = select_reg;
    assign position     = position_reg;
    assign last_frame   = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/time_to_seven_segment_frames.sv
// ----------------------------------------------------------------------------
// time_to_seven_segment_frames
// millisecond count to seven-segment display frames
// ----------------------------------------------------------------------------
// Each accepted time_ms transaction yields min(NUM_DIGITS, 4) frames, leftmost
// digit first; with four digits they show ten-thousands, thousands, hundreds
// and tens of ms, each modulo 10. The binary to decimal converter consumes
// eight input bits a cycle unless a full queue holds its last slice, and
// takes a new transaction as it hands the last one over. The frame emitter
// sends one frame a cycle while out_ready does not stall it. A two-entry
// queue lets the converter keep going while the output stalls. dot_mask is
// written over the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module time_to_seven_segment_frames
    import ttss_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [MASK_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] time_ms,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [SEG_W-1:0]       segments,
    output logic [SEL_W-1:0]       digit_select,
    output logic [POS_W-1:0]       position,
    output logic                   last_frame
);

    logic [MASK_W-1:0] dot_mask_reg;
    q_stat_t           q_stat;
    logic              push;
    logic              pop;
    digit_row_t        push_row;
    digit_row_t        head_row;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dot_mask_reg <= DOT_MASK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            dot_mask_reg <= cfg_data;
        end
    end

    // converter
    ttss_front #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .time_ms  (time_ms),
        .q_stat   (q_stat),
        .push     (push),
        .push_row (push_row)
    );

    // decoupling queue
    ttss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_row (push_row),
        .pop      (pop),
        .q_stat   (q_stat),
        .head_row (head_row)
    );

    // frame emitter
    ttss_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head_row     (head_row),
        .dot_mask     (dot_mask_reg),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .segments     (segments),
        .digit_select (digit_select),
        .position     (position),
        .last_frame   (last_frame)
    );

endmodule

`default_nettype wire

// File: rtl/core/ttss_checker.sv
// ----------------------------------------------------------------------------
// ttss_checker
// port-level checks on frame order and select coding of the display driver
// ----------------------------------------------------------------------------
`default_nettype none

`include "time_to_seven_segment_frames_assert.svh"

module ttss_checker
    import ttss_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire logic [SEG_W-1:0] segments,
    input  wire logic [SEL_W-1:0] digit_select,
    input  wire logic [POS_W-1:0] position,
    input  wire logic             last_frame
);

    localparam int NF = (NUM_DIGITS < MAX_FRAMES) ? NUM_DIGITS : MAX_FRAMES;

    logic frame_done;

    assign frame_done = out_valid && out_ready;

    // frames of one transaction follow without gaps and in order
    `TTSS_ASSERT_NEXT(a_frame_order, clk, rst_n, frame_done && !last_frame, out_valid && (position == POS_W'($past(position) + POS_W'(1))))

    // a transaction that directly follows a final frame starts at the leftmost position
    `TTSS_ASSERT_NEXT(a_restart, clk, rst_n, frame_done && last_frame, !out_valid || (position == '0))

    // final-frame flag matches the position
    `TTSS_ASSERT_IMPLY(a_last_pos, clk, rst_n, out_valid, last_frame == (position == POS_W'(NF - 1)))

    // stalled frame keeps its segment byte and digit select
    `TTSS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(segments) && $stable(digit_select))

endmodule

bind time_to_seven_segment_frames ttss_checker #(
    .NUM_DIGITS (NUM_DIGITS)
) u_ttss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .segments     (segments),
    .digit_select (digit_select),
    .position     (position),
    .last_frame   (last_frame)
);

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench of the millisecond count to seven-segment frame driver
// ----------------------------------------------------------------------------
// A queue of pending counts feeds a clocked driver. Each count that the block
// accepts is run through a local predictor of the four display frames, using
// the current dot mask. A clocked monitor checks every frame that leaves the
// block against the oldest prediction. Between phases the block is drained
// and dot_mask is rewritten. Both sides insert random gaps and stalls, and
// some phases run without any.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import ttss_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 52;
    localparam int NUM_PHASES   = 8;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [SEL_W-1:0] digit_select;
        logic [POS_W-1:0] position;
        logic             last_frame;
    } frame_t;

    // block ports
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [MASK_W-1:0] cfg_data     = '0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [DATA_W-1:0] time_ms      = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [SEG_W-1:0]  segments;
    logic [SEL_W-1:0]  digit_select;
    logic [POS_W-1:0]  position;
    logic              last_frame;

    // testbench state
    logic [DATA_W-1:0] times_pending [$];
    frame_t            frames_due [$];
    logic [MASK_W-1:0] dot_mask_now = DOT_MASK_RESET;
    logic              gaps_on      = 1'b1;
    int                send_gap;
    int                recv_gap;
    int                quiet_cycles;
    int                fail_count   = 0;

    time_to_seven_segment_frames u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .segments     (segments),
        .digit_select (digit_select),
        .position     (position),
        .last_frame   (last_frame)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // active-low common-anode glyphs, decimal point dark
    function automatic logic [SEG_W-1:0] digit_glyph(input int unsigned d);
        logic [SEG_W-1:0] g;
        case (d)
            0:       g = 8'hC0;
            1:       g = 8'hF9;
            2:       g = 8'hA4;
            3:       g = 8'hB0;
            4:       g = 8'h99;
            5:       g = 8'h92;
            6:       g = 8'h82;
            7:       g = 8'hF8;
            8:       g = 8'h80;
            default: g = 8'h90;
        endcase
        return g;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // random count, biased toward digit boundaries and the top of the range
    function automatic logic [DATA_W-1:0] random_time();
        logic [DATA_W-1:0] t;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: t = $urandom;
            4, 5, 6:    t = $urandom_range(0, 99999);
            7:          t = 10000 * $urandom_range(0, 429496) + $urandom_range(0, 20);
            8:          t = $urandom_range(99980, 100019);
            default:    t = 32'hFFFF_FFFF - $urandom_range(0, 50000);
        endcase
        return t;
    endfunction

    // four frames of one count, leftmost digit (ten-thousands of ms) first
    task automatic predict_frames(input logic [DATA_W-1:0] t);
        int unsigned scale;
        int unsigned digit;
        frame_t      f;
        scale = 10000;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            digit          = (t / scale) % 10;
            f.segments     = digit_glyph(digit);
            if (dot_mask_now[i])
                f.segments[SEG_W-1] = 1'b0;
            f.digit_select = SEL_W'(1) << (MAX_FRAMES - 1 - i);
            f.position     = POS_W'(i);
            f.last_frame   = (i == MAX_FRAMES - 1);
            frames_due.push_back(f);
            scale = scale / 10;
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            time_ms  <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                predict_frames(time_ms);
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (times_pending.size() != 0)
            begin
                in_valid <= 1'b1;
                time_ms  <= times_pending.pop_front();
                send_gap <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output monitor and ready stalls
    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("frame transaction with no frame expected: segments %h select %h",
                           segments, digit_select);
                    fail_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (segments !== want.segments)
                    begin
                        $error("segments: expected %h, actual %h", want.segments, segments);
                        fail_count++;
                    end
                    if (digit_select !== want.digit_select)
                    begin
                        $error("digit_select: expected %h, actual %h",
                               want.digit_select, digit_select);
                        fail_count++;
                    end
                    if (position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d", want.position, position);
                        fail_count++;
                    end
                    if (last_frame !== want.last_frame)
                    begin
                        $error("last_frame: expected %b, actual %b",
                               want.last_frame, last_frame);
                        fail_count++;
                    end
                end
            end
            if (recv_gap != 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap  <= pick_gap();
            end
        end
    end

    // cycles without any transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // wait until every count is sent and every frame has come back,
    // checked at the falling edge once the driver outputs have settled
    task automatic wait_drained();
        while (times_pending.size() != 0 || in_valid || frames_due.size() != 0)
            @(negedge clk);
    endtask

    // dot_mask write, only while the block is drained
    task automatic write_dot_mask(input logic [MASK_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        dot_mask_now = value;
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [MASK_W-1:0] mask;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed counts under the reset mask: every digit at every position,
        // digit boundaries, wrap above the leftmost digit, all-zero and all-one
        for (int d = 0; d < 10; d++)
            times_pending.push_back(d * 11111);
        times_pending.push_back(32'd9);
        times_pending.push_back(32'd10);
        times_pending.push_back(32'd99999);
        times_pending.push_back(32'd100000);
        times_pending.push_back(32'd1234567);
        times_pending.push_back(32'd1000000000);
        times_pending.push_back(32'hFFFF_FFFF);
        times_pending.push_back(32'hFFFF_FFF0);
        wait_drained();

        // random phases over several dot masks, extremes first
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       mask = 4'h0;
                1:       mask = 4'hF;
                2:       mask = 4'h1;
                3:       mask = 4'h8;
                4:       mask = 4'h5;
                5:       mask = 4'hA;
                default: mask = $urandom_range(0, 15);
            endcase
            write_dot_mask(mask);
            gaps_on = (p != 2 && p != 5);
            for (int k = 0; k < PHASE_ITEMS; k++)
                times_pending.push_back(random_time());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/ttss_pkg.sv
rtl/core/ttss_front.sv
rtl/core/ttss_queue.sv
rtl/core/ttss_back.sv
rtl/core/time_to_seven_segment_frames.sv
rtl/core/ttss_checker.sv
sim/tb.sv
